// ----- rtl/csed_pkg.sv -----
// types, constants and decode helpers for the c-string escape decoder
// no dependencies; imported by c_string_escape_decoder
`timescale 1ns / 1ps

package csed_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_OCT  = 3'd3,
    MODE_HEX  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_UNTERM = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  // outcome of one character in plain string context
  typedef struct packed {
    logic    emit;
    kind_t   kind;
    logic [7:0] out_byte;
    mode_t   mode;
  } plain_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int OCT_DIGITS = 3;
  localparam int HEX_DIGITS = 2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam logic [7:0] BYTE_BEL = 8'd7;
  localparam logic [7:0] BYTE_BS  = 8'd8;
  localparam logic [7:0] BYTE_FF  = 8'd12;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_TAB = 8'd9;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_7);
  endfunction

  // bit 4 flags a hex digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      d = c - CH_0;
      return {1'b1, d[3:0]};
    end else if ((c >= CH_A) && (c <= CH_F)) begin
      d = c - CH_A + 8'd10;
      return {1'b1, d[3:0]};
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      d = c - CH_UA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic plain_t plain_char(input logic [7:0] c);
    plain_t p;
    p.emit     = 1'b1;
    p.kind     = KIND_BYTE;
    p.out_byte = c;
    p.mode     = MODE_STR;
    if (c == CH_BSLASH) begin
      p.emit     = 1'b0;
      p.out_byte = 8'd0;
      p.mode     = MODE_ESC;
    end else if (c == CH_QUOTE) begin
      p.kind     = KIND_CLOSED;
      p.out_byte = 8'd0;
      p.mode     = MODE_IDLE;
    end
    return p;
  endfunction

endpackage

// ----- rtl/c_string_escape_decoder.sv -----
// c-string literal unescape: input register, single-pass decode, result queue
// depends on csed_pkg
`timescale 1ns / 1ps

// Streaming decoder for double-quoted C-style strings, one character per request.
// Slave side: s_axis_tdata carries the character, s_axis_tuser marks the opening
// quote of a new string. Master side: m_axis_tdata is the decoded byte,
// m_axis_tuser the result kind (byte, closed, unterminated), m_axis_tlast marks
// the final result caused by one input character. A character causes zero, one
// or two results.
// Path: a character waits in the input register and is then decoded into a
// four-entry queue, from which its results are offered on the master side.
// Throughput: one character per cycle while the queue holds at most two
// results; the master side takes at most one result per cycle, and this
// bounds the sustained rate.
// Reset (rst, synchronous) returns the decoder to idle outside any string and
// empties the queue and the input register.
// When the receiver stalls, the queue fills and s_axis_tready drops once the
// held character could no longer be decoded; nothing is lost or reordered.

module c_string_escape_decoder
  import csed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic       s_axis_tuser,   // [0] start_req
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast
);

  // input register
  logic       in_valid;
  logic       in_start;
  logic [7:0] in_ch;

  // decoder state
  mode_t      mode, mode_next;
  logic [1:0] digit_count, digit_count_next;
  logic [8:0] escape_accum, escape_accum_next;

  // result queue
  result_t             queue [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  logic    advance;
  logic    pop;
  logic    emit0, emit1;
  result_t res0, res1;
  plain_t  pc;
  logic [4:0] hx;
  logic [2:0] cnt_inc;
  logic [8:0] acc_oct, acc_hex;
  logic [1:0] push_n;

  assign advance       = in_valid && (count <= QCNT_W'(QDEPTH - 2));
  assign s_axis_tready = !in_valid || advance;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_start <= s_axis_tuser;
      in_ch    <= s_axis_tdata;
    end
  end

  always_comb begin
    pc      = plain_char(in_ch);
    hx      = hex_digit(in_ch);
    cnt_inc = {1'b0, digit_count} + 3'd1;
    acc_oct = {escape_accum[5:0], in_ch[2:0]};
    acc_hex = {escape_accum[4:0], hx[3:0]};

    mode_next         = mode;
    digit_count_next  = digit_count;
    escape_accum_next = escape_accum;
    emit0 = 1'b0;
    emit1 = 1'b0;
    res0  = '{kind: KIND_BYTE, out_byte: 8'd0, last: 1'b0};
    res1  = '{kind: pc.kind, out_byte: pc.out_byte, last: 1'b1};

    if (in_start) begin
      emit0             = (mode != MODE_IDLE);
      res0.kind         = KIND_UNTERM;
      mode_next         = MODE_STR;
      digit_count_next  = 2'd0;
      escape_accum_next = 9'd0;
    end else begin
      unique case (mode)
        MODE_STR: begin
          emit0         = pc.emit;
          res0.kind     = pc.kind;
          res0.out_byte = pc.out_byte;
          mode_next     = pc.mode;
        end
        MODE_ESC: begin
          mode_next = MODE_STR;
          emit0     = 1'b1;
          unique case (in_ch)
            CH_BSLASH, CH_APOS, CH_QUOTE: res0.out_byte = in_ch;
            CH_A: res0.out_byte = BYTE_BEL;
            CH_B: res0.out_byte = BYTE_BS;
            CH_F: res0.out_byte = BYTE_FF;
            CH_N: res0.out_byte = BYTE_LF;
            CH_R: res0.out_byte = BYTE_CR;
            CH_T: res0.out_byte = BYTE_TAB;
            CH_X: begin
              emit0             = 1'b0;
              mode_next         = MODE_HEX;
              digit_count_next  = 2'd0;
              escape_accum_next = 9'd0;
            end
            default: begin
              if (is_oct(in_ch)) begin
                emit0             = 1'b0;
                mode_next         = MODE_OCT;
                digit_count_next  = 2'd1;
                escape_accum_next = {6'd0, in_ch[2:0]};
              end else begin
                emit0         = pc.emit;
                res0.kind     = pc.kind;
                res0.out_byte = pc.out_byte;
                mode_next     = pc.mode;
              end
            end
          endcase
        end
        MODE_OCT: begin
          if (is_oct(in_ch) && (digit_count < 2'(OCT_DIGITS))) begin
            if (cnt_inc >= 3'(OCT_DIGITS)) begin
              emit0             = 1'b1;
              res0.out_byte     = acc_oct[7:0];
              mode_next         = MODE_STR;
              digit_count_next  = 2'd0;
              escape_accum_next = 9'd0;
            end else begin
              digit_count_next  = cnt_inc[1:0];
              escape_accum_next = acc_oct;
            end
          end else begin
            // flush the pending byte, then treat the char as plain
            emit0             = 1'b1;
            res0.out_byte     = escape_accum[7:0];
            emit1             = pc.emit;
            digit_count_next  = 2'd0;
            escape_accum_next = 9'd0;
            mode_next         = pc.mode;
          end
        end
        MODE_HEX: begin
          if (hx[4] && (digit_count < 2'(HEX_DIGITS))) begin
            if (cnt_inc >= 3'(HEX_DIGITS)) begin
              emit0             = 1'b1;
              res0.out_byte     = acc_hex[7:0];
              mode_next         = MODE_STR;
              digit_count_next  = 2'd0;
              escape_accum_next = 9'd0;
            end else begin
              digit_count_next  = cnt_inc[1:0];
              escape_accum_next = acc_hex;
            end
          end else begin
            emit0             = 1'b1;
            res0.out_byte     = escape_accum[7:0];
            emit1             = pc.emit;
            digit_count_next  = 2'd0;
            escape_accum_next = 9'd0;
            mode_next         = pc.mode;
          end
        end
        default: mode_next = MODE_IDLE;
      endcase
    end
    res0.last = !emit1;
    push_n    = advance ? ({1'b0, emit0} + {1'b0, emit1}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      digit_count  <= 2'd0;
      escape_accum <= 9'd0;
    end else if (advance) begin
      mode         <= mode_next;
      digit_count  <= digit_count_next;
      escape_accum <= escape_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push_n) - QCNT_W'(pop);
    end
    if (advance && emit0) begin
      queue[wr_ptr] <= res0;
    end
    if (advance && emit1) begin
      queue[wr_ptr + QPTR_W'(1)] <= res1;
    end
  end

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = queue[rd_ptr].out_byte;
  assign m_axis_tuser  = queue[rd_ptr].kind;
  assign m_axis_tlast  = queue[rd_ptr].last;

  // queue never overflows
  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // a second result only follows a first one
  assert property (@(posedge clk) disable iff (rst) (advance && emit1) |-> emit0)
    else $error("second result without first");

  // octal escape holds one or two digits between characters
  assert property (@(posedge clk) disable iff (rst)
      (mode == MODE_OCT) |-> (digit_count == 2'd1 || digit_count == 2'd2))
    else $error("octal digit count out of range");

  // hex escape holds at most one digit between characters
  assert property (@(posedge clk) disable iff (rst)
      (mode == MODE_HEX) |-> (digit_count <= 2'd1))
    else $error("hex digit count out of range");

  // a held character stays held until it is decoded
  assert property (@(posedge clk) disable iff (rst)
      (in_valid && !advance) |=> (in_valid && $stable(in_ch) && $stable(in_start)))
    else $error("held character lost");

endmodule

// ----- tb/tb_c_string_escape_decoder.sv -----
// self-checking testbench for the c-string escape decoder
// needs csed_pkg and c_string_escape_decoder; checks every result against a built-in predictor
`timescale 1ns / 1ps

module tb_c_string_escape_decoder
  import csed_pkg::*;
();

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;   // [7:0] ch
  logic       s_axis_tuser = 1'b0;   // [0] start_req
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_byte
  logic [1:0] m_axis_tuser;          // [1:0] kind
  logic       m_axis_tlast;

  c_string_escape_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predictor state
  mode_t      dec_mode = MODE_IDLE;
  logic [1:0] dec_digits = 2'd0;
  logic [8:0] dec_accum = 9'd0;
  result_t    step_res[$];
  result_t    decoded_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          chars_decoded = 0;
  int          mismatches = 0;
  result_t     seen_res;
  result_t     want_res;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int hex_val(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_A && c <= CH_F) return int'(c - CH_A) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic void note_result(input kind_t k, input logic [7:0] b);
    result_t r;
    r.kind     = k;
    r.out_byte = (k == KIND_BYTE) ? b : 8'd0;
    r.last     = 1'b0;
    step_res = {step_res, r};
  endfunction

  function automatic void decode_plain(input logic [7:0] c);
    if (c == CH_BSLASH) begin
      dec_mode = MODE_ESC;
    end else if (c == CH_QUOTE) begin
      note_result(KIND_CLOSED, 8'd0);
      dec_mode = MODE_IDLE;
    end else begin
      note_result(KIND_BYTE, c);
      dec_mode = MODE_STR;
    end
  endfunction

  function automatic void clear_escape();
    dec_digits = 2'd0;
    dec_accum  = 9'd0;
  endfunction

  // works out the results of one accepted request and queues them
  function automatic void decode_char(input logic start, input logic [7:0] c);
    int      h;
    result_t r;
    step_res.delete();
    if (start) begin
      if (dec_mode != MODE_IDLE) note_result(KIND_UNTERM, 8'd0);
      dec_mode = MODE_STR;
      clear_escape();
    end else begin
      case (dec_mode)
        MODE_STR: decode_plain(c);
        MODE_ESC: begin
          dec_mode = MODE_STR;
          case (c)
            CH_BSLASH, CH_APOS, CH_QUOTE: note_result(KIND_BYTE, c);
            CH_A: note_result(KIND_BYTE, BYTE_BEL);
            CH_B: note_result(KIND_BYTE, BYTE_BS);
            CH_F: note_result(KIND_BYTE, BYTE_FF);
            CH_N: note_result(KIND_BYTE, BYTE_LF);
            CH_R: note_result(KIND_BYTE, BYTE_CR);
            CH_T: note_result(KIND_BYTE, BYTE_TAB);
            CH_X: begin
              dec_mode = MODE_HEX;
              clear_escape();
            end
            default: begin
              if (c >= CH_0 && c <= CH_7) begin
                dec_mode   = MODE_OCT;
                dec_digits = 2'd1;
                dec_accum  = {6'd0, c[2:0]};
              end else begin
                decode_plain(c);
              end
            end
          endcase
        end
        MODE_OCT: begin
          if (c >= CH_0 && c <= CH_7 && dec_digits < 2'd3) begin
            dec_accum  = {dec_accum[5:0], c[2:0]};
            dec_digits = dec_digits + 2'd1;
            if (dec_digits == 2'd3) begin
              note_result(KIND_BYTE, dec_accum[7:0]);
              dec_mode = MODE_STR;
              clear_escape();
            end
          end else begin
            // pending value goes out ahead of the terminating character
            note_result(KIND_BYTE, dec_accum[7:0]);
            clear_escape();
            decode_plain(c);
          end
        end
        MODE_HEX: begin
          h = hex_val(c);
          if (h >= 0 && dec_digits < 2'd2) begin
            dec_accum  = {dec_accum[4:0], 4'(h)};
            dec_digits = dec_digits + 2'd1;
            if (dec_digits == 2'd2) begin
              note_result(KIND_BYTE, dec_accum[7:0]);
              dec_mode = MODE_STR;
              clear_escape();
            end
          end else begin
            note_result(KIND_BYTE, dec_accum[7:0]);
            clear_escape();
            decode_plain(c);
          end
        end
        default: dec_mode = MODE_IDLE;
      endcase
    end
    foreach (step_res[i]) begin
      r = step_res[i];
      r.last = (i == step_res.size() - 1);
      decoded_q = {decoded_q, r};
    end
  endfunction

  // sample at the falling edge, the values hold until the next rising edge
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_res.kind     = kind_t'(m_axis_tuser);
      seen_res.out_byte = m_axis_tdata;
      seen_res.last     = m_axis_tlast;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches < 100)
          $display("%0t: expected no result, got kind=%0d byte=%02h last=%0b", $time,
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want_res = decoded_q.pop_front();
        if (seen_res.kind !== want_res.kind || seen_res.out_byte !== want_res.out_byte ||
            seen_res.last !== want_res.last) begin
          mismatches++;
          if (mismatches < 100)
            $display("%0t: expected kind=%0d byte=%02h last=%0b, got kind=%0d byte=%02h last=%0b",
                     $time, want_res.kind, want_res.out_byte, want_res.last,
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // called and returns at a rising edge
  task automatic send_char(input logic start, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= start;
    if (start || dec_mode != MODE_IDLE) chars_decoded++;
    decode_char(start, c);
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] named_escape(input int i);
    case (i)
      0: return CH_BSLASH;
      1: return CH_APOS;
      2: return CH_QUOTE;
      3: return CH_A;
      4: return CH_B;
      5: return CH_F;
      6: return CH_N;
      7: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function automatic logic [7:0] random_hex_digit();
    case ($urandom_range(2))
      0: return CH_0 + 8'($urandom_range(9));
      1: return CH_A + 8'($urandom_range(5));
      default: return CH_UA + 8'($urandom_range(5));
    endcase
  endfunction

  // ignored while idle, plain start, restart of an open string
  task automatic test_framing();
    send_char(1'b0, CH_UA);
    send_char(1'b1, 8'hFF);
    send_char(1'b1, 8'h00);
    wait_drained();
  endtask

  task automatic test_named_escapes();
    for (int i = 0; i < 9; i++) begin
      send_char(1'b0, CH_BSLASH);
      send_char(1'b0, named_escape(i));
    end
    // unknown escape keeps the character
    send_char(1'b0, CH_BSLASH);
    send_char(1'b0, 8'hFF);
    wait_drained();
  endtask

  task automatic test_numeric_escapes();
    // three octal digits overflow past 8 bits
    send_char(1'b0, CH_BSLASH);
    send_char(1'b0, CH_7);
    send_char(1'b0, CH_7);
    send_char(1'b0, CH_7);
    send_char(1'b0, CH_BSLASH);
    send_char(1'b0, CH_X);
    send_char(1'b0, CH_UA);
    send_char(1'b0, CH_F);
    // hex escape with no digits
    send_char(1'b0, CH_BSLASH);
    send_char(1'b0, CH_X);
    send_char(1'b0, 8'h67);
    // octal escape closed by the quote: byte then close
    send_char(1'b0, CH_BSLASH);
    send_char(1'b0, CH_0);
    send_char(1'b0, CH_QUOTE);
    send_char(1'b0, CH_B);
    // restart drops a pending escape
    send_char(1'b1, CH_QUOTE);
    send_char(1'b0, CH_BSLASH);
    send_char(1'b0, 8'h31);
    send_char(1'b1, CH_QUOTE);
    send_char(1'b0, CH_QUOTE);
    wait_drained();
  endtask

  task automatic send_random_string();
    int         n_tok;
    int         sel;
    int         n_dig;
    logic [7:0] c;
    send_char(1'b1, 8'($urandom_range(255)));
    n_tok = $urandom_range(12, 1);
    repeat (n_tok) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        c = 8'($urandom_range(255));
        if (c == CH_BSLASH || c == CH_QUOTE) c = c ^ 8'h01;
        send_char(1'b0, c);
      end else if (sel < 60) begin
        send_char(1'b0, CH_BSLASH);
        send_char(1'b0, named_escape($urandom_range(8)));
      end else if (sel < 75) begin
        send_char(1'b0, CH_BSLASH);
        n_dig = $urandom_range(3, 1);
        repeat (n_dig) send_char(1'b0, CH_0 + 8'($urandom_range(7)));
      end else if (sel < 88) begin
        send_char(1'b0, CH_BSLASH);
        send_char(1'b0, CH_X);
        n_dig = $urandom_range(2);
        repeat (n_dig) send_char(1'b0, random_hex_digit());
      end else begin
        send_char(1'b0, CH_BSLASH);
        send_char(1'b0, 8'($urandom_range(255)));
      end
    end
    sel = $urandom_range(99);
    if (sel < 80) send_char(1'b0, CH_QUOTE);
    else if (sel < 90) send_char(1'b0, CH_BSLASH);
    // trailing noise, mostly ignored after the close
    repeat ($urandom_range(2)) send_char($urandom_range(15) == 0, 8'($urandom_range(255)));
  endtask

  task automatic test_random_strings(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int n_chars);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    chars_decoded  = 0;
    while (chars_decoded < n_chars) send_random_string();
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_framing();
    test_named_escapes();
    test_numeric_escapes();
    test_random_strings(0, 0, 440);
    test_random_strings(64, 0, 440);
    test_random_strings(0, 64, 440);
    test_random_strings(25, 25, 440);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
